[src/lcss_pkg.sv]
// Shared types and constants for the trajectory LCSS matcher.
package lcss_pkg;

  // Fixed field widths
  localparam int COORD_W   = 24;
  localparam int STAMP_W   = 32;
  localparam int SCORE_W   = 9;
  localparam int DIST_W    = 50;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DIST_W;

  // Widths of cell arithmetic
  localparam int DIFF_W = COORD_W + 1;      // coordinate difference
  localparam int DT_W   = STAMP_W + 1;      // signed time difference
  localparam int SQ_W   = 2 * COORD_W + 1;  // one square, at most 2^48

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_SQ     = 1'b1;

  // Input word function codes
  localparam logic FUNC_REF   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Query point travelling down the cell chain
  typedef struct packed {
    logic                       vld;
    logic                       fresh;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [STAMP_W-1:0]         t;
  } qry_t;

  // Score handoff between neighboring cells
  typedef struct packed {
    logic               vld;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] diag;
  } scr_t;

endpackage

[src/lcss_cell.sv]
// One LCSS cell: a stored reference point, its score entry and a match pipeline.
module lcss_cell #(
  parameter int IDX_W   = 8,
  parameter int CELL_ID = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lcss_pkg::STAMP_W-1:0]      time_window,
  input  logic [lcss_pkg::DIST_W-1:0]       dist_sq_limit,
  input  logic                              occ_clr,
  input  logic                              wr_en,
  input  logic [IDX_W-1:0]                  wr_idx,
  input  logic signed [lcss_pkg::COORD_W-1:0] wr_x,
  input  logic signed [lcss_pkg::COORD_W-1:0] wr_y,
  input  logic [lcss_pkg::STAMP_W-1:0]      wr_t,
  input  lcss_pkg::qry_t                    q_i,
  output lcss_pkg::qry_t                    q_o,
  input  lcss_pkg::scr_t                    s_i,
  output lcss_pkg::scr_t                    s_o
);
  import lcss_pkg::*;

  // stored reference point and score entry
  logic                      occ_r;
  logic signed [COORD_W-1:0] rx_r;
  logic signed [COORD_W-1:0] ry_r;
  logic [STAMP_W-1:0]        rt_r;
  logic [SCORE_W-1:0]        score_r;

  // match pipeline
  logic                      va_r, fa_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic signed [DT_W-1:0]    dt_r;
  logic                      vb_r, fb_r, tok_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic                      vc_r, fc_r, match_r;

  qry_t                      q_r;
  scr_t                      s_r;

  logic signed [DT_W-1:0]    dt_neg;
  logic [STAMP_W-1:0]        gap;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [DIST_W-1:0]         d2;
  logic [SCORE_W-1:0]        up, inc, best, v;
  logic                      hit;

  assign hit = wr_en && (wr_idx == IDX_W'(CELL_ID));

  // occupancy: a new reference set clears all cells, then the write sets one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      if (occ_clr) occ_r <= 1'b0;
      if (hit) occ_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      rx_r <= wr_x;
      ry_r <= wr_y;
      rt_r <= wr_t;
    end
  end

  // stage A: differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= q_i.vld;
    end
    fa_r <= q_i.fresh;
    dx_r <= DIFF_W'(q_i.x) - DIFF_W'(rx_r);
    dy_r <= DIFF_W'(q_i.y) - DIFF_W'(ry_r);
    dt_r <= $signed({1'b0, q_i.t}) - $signed({1'b0, rt_r});
  end

  // stage B: squares and time test
  assign dt_neg = -dt_r;
  assign gap    = dt_r[DT_W-1] ? dt_neg[STAMP_W-1:0] : dt_r[STAMP_W-1:0];
  assign px     = dx_r * dx_r;
  assign py     = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    fb_r  <= fa_r;
    tok_r <= gap < time_window;
    sqx_r <= px[SQ_W-1:0];
    sqy_r <= py[SQ_W-1:0];
  end

  // stage C: distance test
  assign d2 = DIST_W'(sqx_r) + DIST_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    fc_r    <= fb_r;
    match_r <= tok_r && (d2 < dist_sq_limit);
  end

  // score update, aligned with the neighbor's handoff
  assign up   = fc_r ? '0 : score_r;
  assign inc  = (s_i.diag >= SCORE_MAX) ? SCORE_MAX : s_i.diag + 1'b1;
  assign best = (s_i.left > up) ? s_i.left : up;
  assign v    = match_r ? inc : best;

  always_ff @(posedge clk) begin
    if (vc_r && occ_r) score_r <= v;
  end

  // handoff: empty cells pass the left value straight on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else begin
      s_r.vld <= vc_r;
    end
    if (vc_r) begin
      if (occ_r) begin
        s_r.left <= v;
        s_r.diag <= up;
      end else begin
        s_r.left <= s_i.left;
        s_r.diag <= s_i.diag;
      end
    end
  end

  // query forwarding, one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= q_i.vld;
    end
    q_r.fresh <= q_i.fresh;
    q_r.x     <= q_i.x;
    q_r.y     <= q_i.y;
    q_r.t     <= q_i.t;
  end

  assign q_o = q_r;
  assign s_o = s_r;

endmodule

[src/trajectory_lcss_matcher.sv]
// Top level of the trajectory LCSS matcher: control, configuration and cell chain.
//
// Reference points (func 0) are stored one per cell, one per cycle while idle; points beyond
// MAX_POINTS are dropped, and a reference point following one marked last starts a new set.
// A query point (func 1) travels down the chain of MAX_POINTS cells, one cell per cycle,
// each cell spending three pipeline stages on its time and squared-distance test before it
// updates its score entry and hands it on; the block takes no new word until the score
// leaves the tail of the cell chain, and a point marked last also waits until the output
// register is free. A query point marked last puts the match length in the output
// register; the block keeps taking words while that result waits, and a following
// last query point waits until the result has been taken.
module trajectory_lcss_matcher #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [lcss_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [lcss_pkg::COORD_W-1:0] in_pos_y,
  input  logic [lcss_pkg::STAMP_W-1:0]        in_stamp,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lcss_pkg::SCORE_W-1:0]        out_match_len,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lcss_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [STAMP_W-1:0]   time_window_r;
  logic [DIST_W-1:0]    dist_sq_limit_r;
  logic [CNT_W-1:0]     ref_count_r, ref_count_nxt, eff_count;
  logic                 ref_closed_r;
  logic                 fresh_query_r;
  logic                 last_r;
  logic                 out_valid_r;
  logic [SCORE_W-1:0]   out_match_len_r;
  qry_t                 q_r;

  logic                 in_acc, ref_acc, qry_acc;
  logic                 wr_en, occ_clr, out_load;

  qry_t                 q [0:MAX_POINTS];
  scr_t                 s [0:MAX_POINTS];
  logic [MAX_POINTS:0]  qv;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ref_acc   = in_acc && (in_func == FUNC_REF);
  assign qry_acc   = in_acc && (in_func == FUNC_QUERY);
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_match_len = out_match_len_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_window_r   <= '0;
      dist_sq_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIME_WINDOW: time_window_r   <= cfg_data[STAMP_W-1:0];
        CFG_DIST_SQ:     dist_sq_limit_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // reference set bookkeeping
  assign eff_count = ref_closed_r ? '0 : ref_count_r;
  assign wr_en     = ref_acc && (eff_count < CNT_W'(MAX_POINTS));
  assign occ_clr   = ref_acc && ref_closed_r;
  assign ref_count_nxt = wr_en ? eff_count + 1'b1 : eff_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r   <= '0;
      ref_closed_r  <= 1'b0;
      fresh_query_r <= 1'b1;
    end else if (ref_acc) begin
      ref_count_r   <= ref_count_nxt;
      ref_closed_r  <= in_last;
      fresh_query_r <= 1'b1;
    end else if (qry_acc) begin
      fresh_query_r <= in_last;
    end
  end

  // query launch into the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= qry_acc;
    end
    if (qry_acc) begin
      q_r.fresh <= fresh_query_r;
      q_r.x     <= in_pos_x;
      q_r.y     <= in_pos_y;
      q_r.t     <= in_stamp;
      last_r    <= in_last;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (qry_acc) state_nxt = ST_RUN;
      ST_RUN:  if (s[MAX_POINTS].vld) state_nxt = last_r ? ST_HOLD : ST_IDLE;
      ST_HOLD: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register; the chain tail holds its value until the next query
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) out_match_len_r <= s[MAX_POINTS].left;
  end

  // cell chain with a zero boundary column on its left
  assign q[0] = q_r;
  assign s[0] = '{vld: 1'b0, left: '0, diag: '0};

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    lcss_cell #(
      .IDX_W  (IDX_W),
      .CELL_ID(j)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .time_window  (time_window_r),
      .dist_sq_limit(dist_sq_limit_r),
      .occ_clr      (occ_clr),
      .wr_en        (wr_en),
      .wr_idx       (eff_count[IDX_W-1:0]),
      .wr_x         (in_pos_x),
      .wr_y         (in_pos_y),
      .wr_t         (in_stamp),
      .q_i          (q[j]),
      .q_o          (q[j+1]),
      .s_i          (s[j]),
      .s_o          (s[j+1])
    );
  end

  for (genvar j = 0; j <= MAX_POINTS; j++) begin : g_qv
    assign qv[j] = q[j].vld;
  end

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(qv))
    else $error("more than one query point in the cell chain");

  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    s[MAX_POINTS].vld |-> state_r == ST_RUN)
    else $error("chain tail fired outside a query run");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ref_count_r <= CNT_W'(MAX_POINTS))
    else $error("reference count beyond capacity");

  a_hold_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && !out_valid_r) |=> out_valid_r && state_r == ST_IDLE)
    else $error("pending result not moved to the output register");

endmodule

[tb/sv/lcss_checker.sv]
// Scoreboard for the trajectory LCSS matcher: tracks accepted words, predicts match lengths.
module lcss_checker #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [lcss_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [lcss_pkg::COORD_W-1:0] in_pos_y,
  input  logic [lcss_pkg::STAMP_W-1:0]        in_stamp,
  input  logic                                in_last,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [lcss_pkg::SCORE_W-1:0]        out_match_len,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [lcss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcss_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import lcss_pkg::*;

  // thresholds as last written
  logic [STAMP_W-1:0]        win_secs;
  logic [DIST_W-1:0]         dist_lim;

  // stored reference trajectory
  logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
  logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
  logic [STAMP_W-1:0]        pt_t [MAX_POINTS];
  int                        pt_count;
  logic                      set_closed;

  // dynamic-programming row of the running query sequence
  logic [SCORE_W-1:0]        row [MAX_POINTS];
  logic                      new_seq;

  logic [SCORE_W-1:0]        lcss_len_q [$];
  logic [SCORE_W-1:0]        want;
  int                        errors;

  // time gap and squared distance test against stored point k
  function automatic bit points_close(input logic signed [COORD_W-1:0] qx, qy,
                                      input logic [STAMP_W-1:0] qt, input int k);
    logic [STAMP_W-1:0] gap;
    longint             dx;
    longint             dy;
    gap = (qt >= pt_t[k]) ? qt - pt_t[k] : pt_t[k] - qt;
    dx  = longint'(qx) - longint'(pt_x[k]);
    dy  = longint'(qy) - longint'(pt_y[k]);
    return (gap < win_secs) && ((dx * dx + dy * dy) < longint'({1'b0, dist_lim}));
  endfunction

  // fold one accepted point into the stored set or the score row
  task automatic absorb_point(input logic fn, input logic signed [COORD_W-1:0] qx, qy,
                              input logic [STAMP_W-1:0] qt, input logic is_last);
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] v;
    int                 j;
    if (fn == FUNC_REF) begin
      if (set_closed) begin
        pt_count   = 0;
        set_closed = 1'b0;
      end
      // overflow points are dropped
      if (pt_count < MAX_POINTS) begin
        pt_x[pt_count] = qx;
        pt_y[pt_count] = qy;
        pt_t[pt_count] = qt;
        pt_count++;
      end
      if (is_last) set_closed = 1'b1;
      new_seq = 1'b1;
    end else begin
      if (new_seq) begin
        foreach (row[i]) row[i] = '0;
        new_seq = 1'b0;
      end
      diag = '0;
      left = '0;
      for (j = 0; j < pt_count; j++) begin
        up = row[j];
        if (points_close(qx, qy, qt, j)) begin
          v = (diag == SCORE_MAX) ? SCORE_MAX : diag + 1'b1;
        end else begin
          v = (left > up) ? left : up;
        end
        row[j] = v;
        left   = v;
        diag   = up;
      end
      if (is_last) begin
        lcss_len_q.push_back((pt_count > 0) ? row[pt_count-1] : '0);
        new_seq = 1'b1;
      end
    end
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      win_secs   = '0;
      dist_lim   = '0;
      pt_count   = 0;
      set_closed = 1'b0;
      new_seq    = 1'b1;
      errors     = 0;
      lcss_len_q.delete();
    end else begin
      // compare a taken result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (lcss_len_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: match_len %0d with no result expected", $time, out_match_len);
          end
        end else begin
          want = lcss_len_q.pop_front();
          if (out_match_len !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: match_len expected %0d, got %0d", $time, want, out_match_len);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIME_WINDOW: win_secs = cfg_data[STAMP_W-1:0];
          CFG_DIST_SQ:     dist_lim = cfg_data[DIST_W-1:0];
          default:         ;
        endcase
      end
      if (in_valid && !in_stall) begin
        absorb_point(in_func, in_pos_x, in_pos_y, in_stamp, in_last);
      end
    end
    fail_count <= errors;
    pending    <= lcss_len_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the trajectory LCSS matcher: clock, reset, stimulus and verdict.
module tb_top;
  import lcss_pkg::*;

  localparam int MAX_POINTS   = 256;
  localparam int CHAIN_CYCLES = MAX_POINTS + 6;
  localparam int PHASE_ITEMS  = 100;

  localparam logic [COORD_W-1:0] C_MIN    = 24'h80_0000;
  localparam logic [COORD_W-1:0] C_MAX    = 24'h7F_FFFF;
  localparam logic [STAMP_W-1:0] T_MAX    = 32'hFFFF_FFFF;
  localparam logic [DIST_W-1:0]  DIST_TOP = 50'h2_0000_0000_0000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_func;
  logic signed [COORD_W-1:0] in_pos_x;
  logic signed [COORD_W-1:0] in_pos_y;
  logic [STAMP_W-1:0]        in_stamp;
  logic                      in_last;
  logic                      out_valid;
  logic                      out_stall;
  logic [SCORE_W-1:0]        out_match_len;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  int                        fail_count;
  int                        pending;

  // no idle cycles on either side while set
  bit                        steady;

  // current phase's point spread and the reference set last sent
  bit                        ph_wide;
  int                        ph_span;
  int                        ph_tspan;
  logic [COORD_W-1:0]        base_x;
  logic [COORD_W-1:0]        base_y;
  logic [STAMP_W-1:0]        base_t;
  logic [COORD_W-1:0]        set_x [MAX_POINTS];
  logic [COORD_W-1:0]        set_y [MAX_POINTS];
  logic [STAMP_W-1:0]        set_t [MAX_POINTS];
  int                        set_n;

  trajectory_lcss_matcher #(
    .MAX_POINTS (MAX_POINTS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_stamp      (in_stamp),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_match_len (out_match_len),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lcss_checker #(
    .MAX_POINTS (MAX_POINTS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_stamp      (in_stamp),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_match_len (out_match_len),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int jitter(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // one input word, called and returning at a falling edge; valid stays high afterwards
  task automatic send_point(input logic fn, input logic [COORD_W-1:0] x, y,
                            input logic [STAMP_W-1:0] t, input logic is_last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func  = fn;
    in_pos_x = x;
    in_pos_y = y;
    in_stamp = t;
    in_last  = is_last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_ref(input logic [COORD_W-1:0] x, y, input logic [STAMP_W-1:0] t,
                          input logic is_last);
    send_point(FUNC_REF, x, y, t, is_last);
    if (set_n < MAX_POINTS) begin
      set_x[set_n] = x;
      set_y[set_n] = y;
      set_t[set_n] = t;
      set_n++;
    end
  endtask

  // a point near a stored one, or anywhere in the phase's spread
  task automatic pick_point(input bit near, output logic [COORD_W-1:0] x, y,
                            output logic [STAMP_W-1:0] t);
    int k;
    if (near && set_n > 0) begin
      k = $urandom_range(0, set_n - 1);
      x = set_x[k] + COORD_W'(jitter(ph_span / 2));
      y = set_y[k] + COORD_W'(jitter(ph_span / 2));
      t = set_t[k] + STAMP_W'(jitter(ph_tspan / 2));
    end else if (ph_wide) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      t = $urandom;
    end else begin
      x = base_x + COORD_W'(jitter(ph_span));
      y = base_y + COORD_W'(jitter(ph_span));
      t = base_t + STAMP_W'(jitter(ph_tspan));
    end
  endtask

  // drain everything in flight, including query words that give no result
  task automatic wait_idle();
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (CHAIN_CYCLES + 8) @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [STAMP_W-1:0] win, input logic [DIST_W-1:0] lim);
    wait_idle();
    cfg_index = CFG_TIME_WINDOW;
    cfg_data  = CFG_DATA_W'(win);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index = CFG_DIST_SQ;
    cfg_data  = lim;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly well-formed reference sets followed by query sequences, some noise
  task automatic run_phase(input bit big_set);
    int                 count;
    int                 roll;
    int                 n;
    int                 i;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [STAMP_W-1:0] t;
    count  = 0;
    set_n  = 0;
    base_x = COORD_W'($urandom);
    base_y = COORD_W'($urandom);
    base_t = $urandom;
    // more points than the block can hold
    if (big_set) begin
      for (i = 0; i < MAX_POINTS + 2; i++) begin
        pick_point(1'b0, x, y, t);
        send_ref(x, y, t, i == MAX_POINTS + 1);
      end
    end
    while (count < PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        pick_point(1'b0, x, y, t);
        if (roll < 7) begin
          send_ref(x, y, t, 1'($urandom_range(0, 1)));
        end else begin
          send_point(FUNC_QUERY, x, y, t, 1'($urandom_range(0, 1)));
        end
        count++;
      end else begin
        if (set_n == 0 || roll < 35) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
          set_n = 0;
          for (i = 0; i < n; i++) begin
            pick_point(1'b0, x, y, t);
            send_ref(x, y, t, i == n - 1);
          end
          count += n;
        end
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          pick_point($urandom_range(0, 9) < 7, x, y, t);
          send_point(FUNC_QUERY, x, y, t, i == n - 1);
        end
        count += n;
      end
    end
  endtask

  // result side: stall for a drawn number of cycles per result
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall = 1'b1;
        do @(negedge clk); while (!out_valid);
        repeat (hold - 1) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FUNC_REF;
    in_pos_x  = '0;
    in_pos_y  = '0;
    in_stamp  = '0;
    in_last   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TIME_WINDOW;
    cfg_data  = '0;
    steady    = 1'b0;
    ph_wide   = 1'b0;
    ph_span   = 4;
    ph_tspan  = 4;
    set_n     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // no stored points; then the zero thresholds after reset match nothing
    send_point(FUNC_QUERY, '0, '0, '0, 1'b1);
    send_point(FUNC_REF, 24'd5, 24'd5, 32'd7, 1'b1);
    send_point(FUNC_QUERY, 24'd5, 24'd5, 32'd7, 1'b1);

    // widest thresholds, coordinate and time extremes
    set_thresholds(T_MAX, DIST_TOP);
    send_point(FUNC_REF, C_MIN, C_MIN, '0, 1'b0);
    send_point(FUNC_REF, C_MAX, C_MAX, T_MAX, 1'b1);
    send_point(FUNC_QUERY, C_MAX, C_MAX, T_MAX, 1'b1);
    send_point(FUNC_QUERY, C_MIN, C_MIN, '0, 1'b0);
    send_point(FUNC_QUERY, C_MAX, C_MAX, T_MAX, 1'b1);

    // reference words cut into a running query and start a new set
    send_point(FUNC_QUERY, '0, '0, 32'd5, 1'b0);
    send_point(FUNC_REF, 24'd10, 24'd10, 32'd100, 1'b0);
    send_point(FUNC_REF, 24'd20, 24'd20, 32'd200, 1'b1);
    send_point(FUNC_QUERY, 24'd10, 24'd10, 32'd100, 1'b1);
    send_point(FUNC_QUERY, 24'd10, 24'd10, 32'd100, 1'b0);
    send_point(FUNC_QUERY, 24'd10, 24'd10, 32'd100, 1'b0);
    send_point(FUNC_QUERY, 24'd20, 24'd20, 32'd200, 1'b1);

    // random phases, one threshold setting each
    for (int p = 0; p < 8; p++) begin
      steady = (p % 3 == 1);
      case (p)
        0: begin
          set_thresholds(32'd32, 50'd1_000_000);
          ph_wide = 1'b0; ph_span = 1500; ph_tspan = 40;
        end
        1: begin
          set_thresholds('0, DIST_TOP);
          ph_wide = 1'b0; ph_span = 100; ph_tspan = 10;
        end
        2: begin
          set_thresholds(T_MAX, DIST_TOP);
          ph_wide = 1'b1; ph_span = 6; ph_tspan = 6;
        end
        3: begin
          set_thresholds(T_MAX, '0);
          ph_wide = 1'b0; ph_span = 50; ph_tspan = 50;
        end
        4: begin
          set_thresholds($urandom, DIST_W'({$urandom, $urandom}) & (DIST_TOP - 1'b1));
          ph_wide = 1'b1; ph_span = 6; ph_tspan = 6;
        end
        5: begin
          set_thresholds($urandom_range(1, 100), DIST_W'($urandom_range(0, 4_000_000)));
          ph_wide = 1'b0; ph_span = 2000; ph_tspan = 100;
        end
        6: begin
          // only exact copies match
          set_thresholds(32'd1, 50'd1);
          ph_wide = 1'b0; ph_span = 2; ph_tspan = 2;
        end
        default: begin
          set_thresholds($urandom_range(0, 20), DIST_W'($urandom_range(0, 100_000)));
          ph_wide = 1'b0; ph_span = 300; ph_tspan = 20;
        end
      endcase
      run_phase(p == 0);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/lcss_pkg.sv
src/lcss_cell.sv
src/trajectory_lcss_matcher.sv
tb/sv/lcss_checker.sv
tb/sv/tb_top.sv
